@@ hw/rtl/rc_pwm_capture_failsafe_defines.svh @@
// Assertion macros for the servo pulse capture block.
// Used by the RTL files that carry concurrent checks; depends on nothing.
`ifndef RC_PWM_CAPTURE_FAILSAFE_DEFINES_SVH
`define RC_PWM_CAPTURE_FAILSAFE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rpc assertion failed");
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rpc assertion failed");
`else
`define RPC_ASSERT_IMP(lbl, ante, cons)
`define RPC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/rpc_pkg.sv @@
// Shared types and constants for the servo pulse capture block.
// No dependencies; imported by every module of the block.
`default_nettype none

package rpc_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W     = 4;
    localparam int TS_W     = 16;
    localparam int CNT_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_CH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_MAX  = 2'd3;

    localparam logic [TS_W-1:0] SCALE_RST  = 16'd26214;
    localparam logic [CH_W-1:0] FS_CH_RST  = 4'd3;
    localparam logic [TS_W-1:0] FS_MIN_RST = 16'd1500;
    localparam logic [TS_W-1:0] FS_MAX_RST = 16'd4500;

    // Work queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    // Result queue at the output
    localparam int OUT_DEPTH   = 2;
    localparam int OPTR_W      = 1;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            level;
        logic [TS_W-1:0] timestamp;
    } t_req;

    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic [TS_W-1:0]  pulse_width;
        logic [CNT_W-1:0] good_pulse_count;
        logic             signal_lost;
    } t_rsp;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic [TS_W-1:0] raw;
    } t_work;

endpackage

`default_nettype wire

@@ hw/rtl/rpc_front.sv @@
// Front end: takes edge requests, keeps per-channel rise times and
// emits raw pulse widths for falling edges. Depends on rpc_pkg.
`default_nettype none

module rpc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rpc_pkg::t_req i_req,
    output logic               o_full,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output rpc_pkg::t_work     o_q_data
);
    import rpc_pkg::*;

    logic [TS_W-1:0]     r_rise [CHANNELS];
    logic                w_accept;
    logic                w_in_range;
    logic [CH_IDX_W-1:0] w_idx;

    assign w_accept   = i_push && !i_q_full;
    assign w_in_range = (i_req.channel != '0) && (i_req.channel <= CH_W'(CHANNELS));
    assign w_idx      = CH_IDX_W'(i_req.channel - CH_W'(1));

    assign o_full           = i_q_full;
    assign o_q_push         = w_accept && w_in_range && !i_req.level;
    assign o_q_data.channel = i_req.channel;
    // Wrapped difference against the stored rise time
    assign o_q_data.raw     = i_req.timestamp - r_rise[w_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_rise[i] <= '0;
            end
        end else if (w_accept && w_in_range && i_req.level) begin
            r_rise[w_idx] <= i_req.timestamp;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rpc_queue.sv @@
// Short work queue between front and back end.
// Depends on rpc_pkg for the entry type and depth.
`default_nettype none

module rpc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rpc_pkg::t_work i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output rpc_pkg::t_work      o_data
);
    import rpc_pkg::*;

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_cnt;
    logic [QPTR_W:0]   n_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rpc_back.sv @@
// Back end: configuration registers, width scaling, failsafe window
// check and the result queue. Depends on rpc_pkg and the assertion macros.
`default_nettype none
`include "rc_pwm_capture_failsafe_defines.svh"

module rpc_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rpc_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_q_empty,
    input  wire rpc_pkg::t_work                i_q_data,
    output logic                               o_q_pop,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output rpc_pkg::t_rsp                      o_rsp
);
    import rpc_pkg::*;

    logic [TS_W-1:0]   r_scale;
    logic [CH_W-1:0]   r_fs_ch;
    logic [TS_W-1:0]   r_fs_min;
    logic [TS_W-1:0]   r_fs_max;

    logic              r_s1_vld;
    logic [CH_W-1:0]   r_s1_ch;
    logic [TS_W-1:0]   r_s1_width;
    logic [2*TS_W-1:0] w_prod;
    logic              w_s1_adv;
    logic              w_s1_load;

    logic [CNT_W-1:0]  r_good_cnt;
    logic [CNT_W-1:0]  n_good_cnt;
    logic              w_lost;
    t_rsp              w_rsp;

    t_rsp              r_oq [OUT_DEPTH];
    logic [OPTR_W-1:0] r_owr;
    logic [OPTR_W-1:0] r_ord;
    logic [OPTR_W:0]   r_ocnt;
    logic              w_ofull;
    logic              w_opop;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_RST;
            r_fs_ch  <= FS_CH_RST;
            r_fs_min <= FS_MIN_RST;
            r_fs_max <= FS_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE:  r_scale  <= i_cfg_data;
                CFG_FS_CH:  r_fs_ch  <= i_cfg_data[CH_W-1:0];
                CFG_FS_MIN: r_fs_min <= i_cfg_data;
                CFG_FS_MAX: r_fs_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Multiply stage
    assign w_ofull   = (r_ocnt == (OPTR_W+1)'(OUT_DEPTH));
    assign w_s1_adv  = r_s1_vld && !w_ofull;
    assign w_s1_load = !i_q_empty && (!r_s1_vld || w_s1_adv);
    assign o_q_pop   = w_s1_load;
    assign w_prod    = {{TS_W{1'b0}}, i_q_data.raw} * {{TS_W{1'b0}}, r_scale};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_ch    <= i_q_data.channel;
            r_s1_width <= w_prod[2*TS_W-1:TS_W];
        end
    end

    // Failsafe window check and counter update
    always_comb begin
        n_good_cnt = r_good_cnt;
        w_lost     = 1'b0;
        if (r_s1_ch == r_fs_ch) begin
            if ((r_s1_width > r_fs_min) && (r_s1_width < r_fs_max)) begin
                if (r_good_cnt != '1) begin
                    n_good_cnt = r_good_cnt + 1'b1;
                end
            end else begin
                n_good_cnt = '0;
                w_lost     = 1'b1;
            end
        end
        w_rsp.out_channel      = r_s1_ch;
        w_rsp.pulse_width      = r_s1_width;
        w_rsp.good_pulse_count = n_good_cnt;
        w_rsp.signal_lost      = w_lost;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good_cnt <= '0;
        end else if (w_s1_adv) begin
            r_good_cnt <= n_good_cnt;
        end
    end

    // Result queue
    assign o_empty = (r_ocnt == '0);
    assign o_rsp   = r_oq[r_ord];
    assign w_opop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_oq[r_owr] <= w_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            if (w_s1_adv) begin
                r_owr <= r_owr + 1'b1;
            end
            if (w_opop) begin
                r_ord <= r_ord + 1'b1;
            end
            if (w_s1_adv && !w_opop) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (w_opop && !w_s1_adv) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

    `RPC_ASSERT_IMP(a_lost_clears_cnt, w_s1_adv && w_lost, n_good_cnt == '0)
    `RPC_ASSERT_NXT(a_s1_hold, r_s1_vld && !w_s1_adv, r_s1_vld && $stable(r_s1_width) && $stable(r_s1_ch))
    `RPC_ASSERT_IMP(a_cnt_step, (r_good_cnt != $past(r_good_cnt)) && (r_good_cnt != '0), r_good_cnt == $past(r_good_cnt) + 1'b1)
    `RPC_ASSERT_IMP(a_oq_bound, 1'b1, r_ocnt <= (OPTR_W+1)'(OUT_DEPTH))

endmodule

`default_nettype wire

@@ hw/rtl/rc_pwm_capture_failsafe.sv @@
// Servo pulse-width capture with failsafe link check.
// Channels: request queue (i_push / o_full, payload i_req) carries edge events;
//   result queue (o_empty / i_pop, payload o_rsp) holds one result per falling edge
//   on channels 1..8; rising edges store the rise time and give no result.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at once
//   (scale factor, failsafe channel, window min, window max). Write while idle.
// Path: an accepted falling edge goes through the work queue and the multiply stage
//   register into the result queue. Throughput: one request per cycle while o_full
//   is low; the front reads the rise table and subtracts, one 16x16 multiply stage
//   follows, the window check sits in front of the result queue.
// Reset (synchronous, i_rst_n low): rise times and the good-pulse counter
//   clear, registers take their defaults, both queues empty.
// When the receiver stalls, the two-entry result queue fills, the multiply
//   stage holds, then the four-entry work queue fills and o_full rises.
// Depends on rpc_pkg, rpc_front, rpc_queue and rpc_back.
`default_nettype none

module rc_pwm_capture_failsafe (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire rpc_pkg::t_req                 i_req,
    output logic                               o_full,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output rpc_pkg::t_rsp                      o_rsp,
    input  wire logic                          i_cfg_we,
    input  wire logic [rpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rpc_pkg::CFG_W-1:0]     i_cfg_data
);
    import rpc_pkg::*;

    logic  w_q_full;
    logic  w_q_push;
    t_work w_q_wdata;
    logic  w_q_empty;
    logic  w_q_pop;
    t_work w_q_rdata;

    rpc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_req    (i_req),
        .o_full   (o_full),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_data (w_q_wdata)
    );

    rpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_rdata)
    );

    rpc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_empty  (w_q_empty),
        .i_q_data   (w_q_rdata),
        .o_q_pop    (w_q_pop),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_rsp      (o_rsp)
    );

endmodule

`default_nettype wire

@@ test/rc_pwm_capture_failsafe_check.sv @@
// Checker for the servo pulse capture block: watches the request, result and
// register ports, predicts every width report and compares it field by field.
// Depends on rpc_pkg for the payload types and register indexes.
module rc_pwm_capture_failsafe_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  rpc_pkg::t_req                 i_req,
    input  logic                          i_empty,
    input  logic                          i_pop,
    input  rpc_pkg::t_rsp                 i_rsp,
    input  logic                          i_cfg_we,
    input  logic [rpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rpc_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_reports,
    output int                            o_lost_seen
);
    import rpc_pkg::*;

    logic [TS_W-1:0]  rise_stamp [CHANNELS];
    logic [CNT_W-1:0] good_run;
    logic [CFG_W-1:0] scale_q;
    logic [CH_W-1:0]  fs_chan;
    logic [CFG_W-1:0] fs_lo;
    logic [CFG_W-1:0] fs_hi;

    t_rsp widths_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_reports    = 0;
        o_lost_seen  = 0;
    end

    // Work out the width report for one edge event, if it makes one.
    task automatic capture_edge(input t_req ev);
        int               idx;
        logic [TS_W-1:0]  raw;
        logic [31:0]      prod;
        t_rsp             rep;
        if (ev.channel == 0 || ev.channel > CHANNELS)
            return;
        idx = ev.channel - 1;
        if (ev.level) begin
            rise_stamp[idx] = ev.timestamp;
            return;
        end
        raw  = ev.timestamp - rise_stamp[idx];
        prod = raw * scale_q;
        rep.out_channel = ev.channel;
        rep.pulse_width = prod[31:16];
        rep.signal_lost = 1'b0;
        if (ev.channel == fs_chan) begin
            if (prod[31:16] > fs_lo && prod[31:16] < fs_hi) begin
                if (good_run != '1)
                    good_run = good_run + 1'b1;
            end else begin
                good_run = '0;
                rep.signal_lost = 1'b1;
            end
        end
        rep.good_pulse_count = good_run;
        widths_due.push_back(rep);
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            foreach (rise_stamp[i])
                rise_stamp[i] = '0;
            good_run = '0;
            scale_q  = SCALE_RST;
            fs_chan  = FS_CH_RST;
            fs_lo    = FS_MIN_RST;
            fs_hi    = FS_MAX_RST;
            widths_due.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SCALE:  scale_q = i_cfg_data;
                    CFG_FS_CH:  fs_chan = i_cfg_data[CH_W-1:0];
                    CFG_FS_MIN: fs_lo   = i_cfg_data;
                    CFG_FS_MAX: fs_hi   = i_cfg_data;
                    default: ;
                endcase
            end
            // Compare the popped result before queueing anything new.
            if (i_pop && !i_empty) begin
                if (widths_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, i_rsp);
                    o_fail_count++;
                end else begin
                    want = widths_due.pop_front();
                    check_field("out_channel", 32'(want.out_channel),
                                32'(i_rsp.out_channel));
                    check_field("pulse_width", 32'(want.pulse_width),
                                32'(i_rsp.pulse_width));
                    check_field("good_pulse_count", 32'(want.good_pulse_count),
                                32'(i_rsp.good_pulse_count));
                    check_field("signal_lost", 32'(want.signal_lost),
                                32'(i_rsp.signal_lost));
                    o_reports++;
                    if (want.signal_lost)
                        o_lost_seen++;
                end
            end
            if (i_push && !i_full)
                capture_edge(i_req);
            o_pending <= widths_due.size();
        end
    end

endmodule

@@ test/rc_pwm_capture_failsafe_test.sv @@
// Testbench top for rc_pwm_capture_failsafe: clock, reset, edge-event stimulus,
// register setups and the verdict. Depends on rpc_pkg, the block itself and
// rc_pwm_capture_failsafe_check, which does all prediction and comparison.
module rc_pwm_capture_failsafe_test;
    import rpc_pkg::*;

    localparam logic LVL_RISE    = 1'b1;
    localparam logic LVL_FALL    = 1'b0;
    localparam int   LIMIT       = 1_000_000;
    localparam int   DRAIN       = 6;
    localparam int   RAND_PHASES = 8;
    localparam int   PHASE_ITEMS = 50;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    t_req                 req;
    logic                 full;
    logic                 empty;
    logic                 pop;
    t_rsp                 rsp;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int reports;
    int lost_seen;
    int sent;
    int setups;
    int cycles;
    int send_idle;
    int pop_stall;

    rc_pwm_capture_failsafe dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_push     (push),
        .i_req      (req),
        .o_full     (full),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_rsp      (rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rc_pwm_capture_failsafe_check check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_req        (req),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_rsp        (rsp),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_reports    (reports),
        .o_lost_seen  (lost_seen)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("rc_pwm_capture_failsafe test failed");
            $finish;
        end
    end

    always @(posedge clk)
        pop <= rst_n && ($urandom_range(99) >= pop_stall);

    task automatic send_edge(input logic [CH_W-1:0] ch, input logic lvl,
                             input logic [TS_W-1:0] ts);
        t_req ev;
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge clk);
        end
        ev.channel   = ch;
        ev.level     = lvl;
        ev.timestamp = ts;
        push <= 1'b1;
        req  <= ev;
        do @(posedge clk); while (full);
        sent++;
    endtask

    task automatic send_pulse(input logic [CH_W-1:0] ch, input logic [TS_W-1:0] t0,
                              input logic [TS_W-1:0] width);
        send_edge(ch, LVL_RISE, t0);
        send_edge(ch, LVL_FALL, t0 + width);
    endtask

    // Wait until every expected report is out, then let the pipeline empty.
    task automatic settle();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic load_setup(input logic [CFG_W-1:0] sc, input logic [CFG_W-1:0] fc,
                              input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SCALE;
        cfg_data <= sc;
        @(posedge clk);
        cfg_idx  <= CFG_FS_CH;
        cfg_data <= fc;
        @(posedge clk);
        cfg_idx  <= CFG_FS_MIN;
        cfg_data <= lo;
        @(posedge clk);
        cfg_idx  <= CFG_FS_MAX;
        cfg_data <= hi;
        @(posedge clk);
        cfg_we   <= 1'b0;
        setups++;
    endtask

    initial begin
        logic [CFG_W-1:0] sc, fc, lo, hi;
        logic [CH_W-1:0]  ch;
        logic [TS_W-1:0]  t0, w;
        logic             fs_live;
        int               n, pick, s;

        rst_n     = 1'b0;
        push      = 1'b0;
        req       = '0;
        pop       = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_SCALE;
        cfg_data  = '0;
        sent      = 0;
        setups    = 0;
        cycles    = 0;
        send_idle = 0;
        pop_stall = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset setup.
        send_edge(4'd0, LVL_RISE, 16'h1234);        // channel zero, dropped
        send_edge(4'd15, LVL_FALL, 16'hFFFF);       // above range, dropped
        send_edge(4'd9, LVL_FALL, 16'h0100);        // above range, dropped
        send_edge(4'd5, LVL_FALL, 16'd1000);        // fall with no rise seen
        send_pulse(4'd1, 16'd0, 16'hFFFF);          // widest pulse
        send_pulse(4'd8, 16'd65000, 16'd2036);      // timer wraps
        send_pulse(4'd7, 16'd100, 16'd3000);
        send_pulse(4'd3, 16'd10000, 16'd5000);      // good failsafe pulse
        send_edge(4'd3, LVL_FALL, 16'd15000);       // same width again
        send_pulse(4'd3, 16'd0, 16'd3751);          // scaled equals window min
        send_pulse(4'd3, 16'd0, 16'd11251);         // scaled equals window max
        send_pulse(4'd3, 16'd0, 16'd5000);
        send_pulse(4'd2, 16'hFFFF, 16'd0);          // zero width
        send_edge(4'd4, LVL_RISE, 16'h8000);
        send_pulse(4'd6, 16'h5555, 16'h5555);
        send_edge(4'd4, LVL_FALL, 16'h7FFF);
        settle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin
                    sc = 16'd0;  fc = 16'd1;  lo = 16'd0;  hi = 16'hFFFF;
                end
                1: begin
                    sc = 16'hFFFF;  fc = 16'd0;
                    lo = CFG_W'($urandom);  hi = CFG_W'($urandom);
                end
                2: begin
                    sc = CFG_W'($urandom_range(65535, 1));  fc = CFG_W'(CHANNELS);
                    lo = 16'd0;  hi = 16'hFFFF;
                end
                3: begin
                    // Inverted window: every failsafe pulse is lost.
                    sc = CFG_W'($urandom_range(65535, 1));  fc = 16'd2;
                    lo = 16'hFFFF;  hi = 16'd0;
                end
                4: begin
                    sc = CFG_W'($urandom_range(65535, 1));  fc = 16'd15;
                    lo = CFG_W'($urandom);  hi = CFG_W'($urandom);
                end
                5: begin
                    sc = CFG_W'($urandom_range(65535, 1));  fc = 16'd4;
                    lo = CFG_W'($urandom_range(65534));  hi = lo + 16'd1;
                end
                default: begin
                    sc = CFG_W'($urandom_range(65535, 1));
                    fc = CFG_W'($urandom_range(CHANNELS, 1));
                    lo = CFG_W'($urandom_range(30000));
                    hi = lo + CFG_W'($urandom_range(20000, 2));
                end
            endcase
            load_setup(sc, fc, lo, hi);
            fs_live = (fc >= 1 && fc <= CHANNELS);
            case (p % 4)
                0: begin send_idle = 0;  pop_stall = 0;  end
                1: begin send_idle = 52; pop_stall = 0;  end
                2: begin send_idle = 0;  pop_stall = 52; end
                default: begin send_idle = 11; pop_stall = 11; end
            endcase

            n = 0;
            while (n < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (fs_live && $urandom_range(1))
                    ch = fc[CH_W-1:0];
                else
                    ch = CH_W'($urandom_range(CHANNELS, 1));
                t0 = TS_W'($urandom);
                if (pick < 80) begin
                    // Aim most widths at the edges of the failsafe window.
                    if (pick < 48 && sc != 0) begin
                        s = $urandom_range(int'(hi) + 2, int'(lo));
                        w = TS_W'(((longint'(s) << 16) + sc - 1) / sc);
                    end else begin
                        w = TS_W'($urandom);
                    end
                    send_pulse(ch, t0, w);
                    n += 2;
                end else if (pick < 90) begin
                    send_edge(ch, pick[0], t0);
                    n++;
                end else begin
                    send_edge(CH_W'($urandom_range(15)), 1'($urandom_range(1)), t0);
                end
            end
            settle();
        end

        $display("%0d edge requests over %0d register setups, stalls on both sides;",
                 sent, setups);
        $display("%0d width reports checked, %0d of them flagging signal loss",
                 reports, lost_seen);
        if (fail_count == 0)
            $display("rc_pwm_capture_failsafe test passed");
        else
            $display("rc_pwm_capture_failsafe test failed");
        $finish;
    end

endmodule

@@ rc_pwm_capture_failsafe.f @@
+incdir+hw/rtl
hw/rtl/rpc_pkg.sv
hw/rtl/rpc_front.sv
hw/rtl/rpc_queue.sv
hw/rtl/rpc_back.sv
hw/rtl/rc_pwm_capture_failsafe.sv
test/rc_pwm_capture_failsafe_check.sv
test/rc_pwm_capture_failsafe_test.sv
